/* hw/rtl/upd_pkg.sv */
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

	localparam int unsigned MAX_OUT = 3;
	localparam int unsigned CNT_W   = 2;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] HEX_ALPHA  = 8'd10;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} result_t;

	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] data;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
	} bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CHAR_0) && (c <= CHAR_9)) ||
			((c >= CHAR_UA) && (c <= CHAR_UF)) ||
			((c >= CHAR_LA) && (c <= CHAR_LF));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = c - CHAR_0;
		if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
			d = c - CHAR_UA + HEX_ALPHA;
		end else if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
			d = c - CHAR_LA + HEX_ALPHA;
		end
		return d[3:0];
	endfunction

endpackage

/* hw/rtl/url_percent_decoder_unit.sv */
// Streaming URL percent decoder (form style, plus as space): top level.
// One encoded byte is taken per cycle whenever full is low, and decoded bytes leave one per
// cycle while pop is high and empty is low; a beat's bytes are registered in the queue. An input
// beat yields zero to three output bytes: a held escape releases its bytes when it resolves or
// when the string ends. The front end keeps the escape state and writes each beat's bytes as
// one bundle into a four-entry queue; the back end hands them out byte by byte, so full rises
// only when four bundles are waiting, and the output rate of one byte per cycle is what a
// stream of bad escapes can outrun.
module url_percent_decoder_unit import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic    accept;
	logic    wr_en;
	bundle_t wr_data;
	logic    rd_en;
	bundle_t head;
	logic    valid;

	assign accept = push && !full;

	upd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.accept  (accept),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	upd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (rd_en),
		.rd_data (head),
		.valid   (valid)
	);

	upd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.valid  (valid),
		.rd_en  (rd_en),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

/* hw/rtl/upd_front.sv */
// Front end: tracks the escape state and turns each input beat into a bundle of output bytes.
module upd_front import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    accept,
	output logic    wr_en,
	output bundle_t wr_data
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	logic [1:0]              phase_q;
	logic [7:0]              held_q;
	logic [1:0]              phase_nxt;
	logic [7:0]              held_nxt;
	logic [MAX_OUT-1:0][7:0] data;
	logic [CNT_W-1:0]        cnt;
	logic                    do_idle;
	logic [7:0]              b;

	always_comb begin
		b         = item.in_byte;
		data      = '0;
		cnt       = '0;
		phase_nxt = PH_IDLE;
		held_nxt  = held_q;
		do_idle   = 1'b0;
		unique case (phase_q)
			PH_PCT: begin
				if (is_hex(b)) begin
					phase_nxt = PH_DIGIT;
					held_nxt  = b;
				end else begin
					data[cnt] = CHAR_PCT;
					cnt       = cnt + 2'd1;
					do_idle   = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (is_hex(b)) begin
					data[cnt] = {hex_val(held_q), hex_val(b)};
					cnt       = cnt + 2'd1;
				end else begin
					data[cnt] = CHAR_PCT;
					cnt       = cnt + 2'd1;
					data[cnt] = held_q;
					cnt       = cnt + 2'd1;
					do_idle   = 1'b1;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase
		if (do_idle) begin
			if (b == CHAR_PCT) begin
				phase_nxt = PH_PCT;
			end else begin
				data[cnt] = (b == CHAR_PLUS) ? CHAR_SPACE : b;
				cnt       = cnt + 2'd1;
			end
		end
		if (item.in_last) begin
			if (phase_nxt == PH_PCT) begin
				data[cnt] = CHAR_PCT;
				cnt       = cnt + 2'd1;
			end else if (phase_nxt == PH_DIGIT) begin
				data[cnt] = CHAR_PCT;
				cnt       = cnt + 2'd1;
				data[cnt] = held_nxt;
				cnt       = cnt + 2'd1;
			end
			phase_nxt = PH_IDLE;
			held_nxt  = '0;
		end
	end

	assign wr_data.data = data;
	assign wr_data.cnt  = cnt;
	assign wr_data.last = item.in_last;
	assign wr_en        = accept && (cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

endmodule

/* hw/rtl/upd_fifo.sv */
// Short queue of byte bundles between the front end and the serializer.
module upd_fifo import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  bundle_t wr_data,
	output logic    full,
	input  logic    rd_en,
	output bundle_t rd_data,
	output logic    valid
);

	bundle_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_AW:0]   count_q;

	assign full    = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/upd_back.sv */
// Back end: walks through the head bundle and presents one decoded byte per beat.
module upd_back import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t head,
	input  logic    valid,
	output logic    rd_en,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic [CNT_W-1:0] idx_q;
	logic             at_end;
	logic             take;

	assign at_end          = (idx_q == head.cnt - 2'd1);
	assign take            = pop && valid;
	assign rd_en           = take && at_end;
	assign empty           = !valid;
	assign result.out_byte = head.data[idx_q];
	assign result.out_last = head.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= at_end ? '0 : idx_q + 2'd1;
		end
	end

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (head.cnt != '0))
		else $error("Queued bundle carries no bytes.");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (idx_q < head.cnt))
		else $error("Byte index runs past the head bundle.");

	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !at_end) |=> (idx_q == $past(idx_q) + 2'd1))
		else $error("Byte index did not advance after a beat.");

	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (idx_q == '0))
		else $error("Byte index not cleared after the bundle was retired.");

endmodule
